### hdl/tach_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and controller/datapath interface types for the
// tachometer moving-average core. No dependencies.
package tach_pkg;

	localparam int COUNT_W   = 32;
	localparam int SCALE_W   = 16;
	localparam int SPEED_W   = 48;
	localparam int SAMPLES_W = 7;
	localparam int STEP_W    = 6;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd300;
	localparam logic [STEP_W-1:0]  LAST_STEP   = 6'd47;

	typedef struct packed {
		logic capture;
		logic update;
		logic mul;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

endpackage

### hdl/tach_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the moving-average core: one transaction at a time through
// capture, update, multiply, serial divide and output hand-off. Uses tach_pkg.
module tach_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output tach_pkg::cmd_t cmd,
	input  tach_pkg::sts_t sts
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_HOLD = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/tach_dpath.sv
`timescale 1ns / 1ps
// Datapath: delta ring memory, running sum, fill count, scale register,
// 32x16 multiply and restoring bit-serial divide by the fill. Uses tach_pkg.
module tach_dpath #(
	parameter int WINDOW = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tach_pkg::SCALE_W-1:0]      cfg_wdata,
	input  logic [tach_pkg::COUNT_W-1:0]      pulse_count,
	input  tach_pkg::cmd_t                    cmd,
	output tach_pkg::sts_t                    sts,
	output logic [tach_pkg::SPEED_W-1:0]      speed_rpm,
	output logic [tach_pkg::SAMPLES_W-1:0]    samples_in_window
);

	localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FW = $clog2(WINDOW + 1);
	localparam int RW = FW + 1;
	localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW);

	logic [tach_pkg::COUNT_W-1:0]   delta_ring [WINDOW];
	logic [tach_pkg::COUNT_W-1:0]   old_q;
	logic [tach_pkg::COUNT_W-1:0]   delta_q;
	logic [tach_pkg::COUNT_W-1:0]   prev_q;
	logic [tach_pkg::COUNT_W-1:0]   sum_q;
	logic [tach_pkg::COUNT_W-1:0]   old_val;
	logic [tach_pkg::SCALE_W-1:0]   scale_q;
	logic [PW-1:0]                  pos_q;
	logic [FW-1:0]                  fill_q;
	logic [tach_pkg::SPEED_W-1:0]   quo_q;
	logic [FW-1:0]                  rem_q;
	logic [tach_pkg::STEP_W-1:0]    step_q;
	logic [tach_pkg::SPEED_W-1:0]   speed_q;
	logic [tach_pkg::SAMPLES_W-1:0] samples_q;
	logic [RW-1:0]                  trial;
	logic [RW-1:0]                  trial_sub;
	logic                           take;

	// a slot that has not been written since reset reads as zero
	assign old_val   = (fill_q == FILL_MAX) ? old_q : '0;
	assign trial     = {rem_q, quo_q[tach_pkg::SPEED_W-1]};
	assign take      = (trial >= RW'(fill_q));
	assign trial_sub = trial - RW'(fill_q);
	assign sts.div_last = (step_q == tach_pkg::LAST_STEP);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			old_q <= delta_ring[pos_q];
		end
		if (cmd.update) begin
			delta_ring[pos_q] <= delta_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= tach_pkg::SCALE_RESET;
			prev_q  <= '0;
			sum_q   <= '0;
			pos_q   <= '0;
			fill_q  <= '0;
			step_q  <= '0;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (cmd.capture) begin
				prev_q <= pulse_count;
			end
			if (cmd.update) begin
				sum_q <= sum_q - old_val + delta_q;
				pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
				if (fill_q != FILL_MAX) begin
					fill_q <= fill_q + FW'(1);
				end
			end
			if (cmd.mul) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + tach_pkg::STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			delta_q <= pulse_count - prev_q;
		end
		if (cmd.mul) begin
			quo_q <= tach_pkg::SPEED_W'(sum_q) * tach_pkg::SPEED_W'(scale_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[tach_pkg::SPEED_W-2:0], take};
			rem_q <= take ? trial_sub[FW-1:0] : trial[FW-1:0];
		end
		if (cmd.load_out) begin
			speed_q   <= quo_q;
			samples_q <= tach_pkg::SAMPLES_W'(fill_q);
		end
	end

	assign speed_rpm         = speed_q;
	assign samples_in_window = samples_q;

endmodule

### hdl/tach_rpm_moving_average_core.sv
`timescale 1ns / 1ps
// Top level of the tachometer moving-average core: controller plus datapath.
// Uses tach_pkg, tach_ctrl and tach_dpath.

// Each accepted pulse_count gives one result: speed_rpm = floor(sum of the last
// WINDOW count deltas (mod 2^32) * rpm_scale / samples_in_window), where
// samples_in_window counts samples since reset and saturates at WINDOW. A
// transaction passes capture, update, multiply and the 48-step bit-serial
// divider; the next sample is accepted once the result is in the output
// register, which waits until the previous result is taken. rpm_scale resets
// to 300; the user must write it only while the core is idle, which the
// core does not enforce. No clearing pass is needed after reset.
module tach_rpm_moving_average_core #(
	parameter int WINDOW = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tach_pkg::SCALE_W-1:0]    cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tach_pkg::COUNT_W-1:0]    pulse_count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tach_pkg::SPEED_W-1:0]    speed_rpm,
	output logic [tach_pkg::SAMPLES_W-1:0]  samples_in_window
);

	tach_pkg::cmd_t cmd;
	tach_pkg::sts_t sts;

	tach_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tach_dpath #(
		.WINDOW (WINDOW)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.pulse_count       (pulse_count),
		.cmd               (cmd),
		.sts               (sts),
		.speed_rpm         (speed_rpm),
		.samples_in_window (samples_in_window)
	);

`ifndef NO_ASSERTIONS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction accepted while one is in progress");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (samples_in_window != '0) &&
			(samples_in_window <= tach_pkg::SAMPLES_W'(WINDOW)))
		else $error("samples_in_window out of range on a valid result");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared straight after acceptance");
`endif

endmodule

### tb/tach_rpm_moving_average_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tach_rpm_moving_average_core: directed and random pulse counts,
// rpm_scale changes between phases, random stalls on both sides and two long output hold-offs.
// Depends on tach_pkg and the core RTL only.
module tach_rpm_moving_average_core_tb;

	localparam int WINDOW       = 10;
	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 115;
	localparam int MAX_REPORTS  = 200;

	typedef struct packed {
		logic [tach_pkg::SPEED_W-1:0]   speed;
		logic [tach_pkg::SAMPLES_W-1:0] samples;
	} speed_result_t;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           cfg_we      = 1'b0;
	logic [tach_pkg::SCALE_W-1:0]   cfg_wdata   = '0;
	logic                           in_valid    = 1'b0;
	logic                           in_ready;
	logic [tach_pkg::COUNT_W-1:0]   pulse_count = '0;
	logic                           out_valid;
	logic                           out_ready   = 1'b0;
	logic [tach_pkg::SPEED_W-1:0]   speed_rpm;
	logic [tach_pkg::SAMPLES_W-1:0] samples_in_window;

	logic [tach_pkg::COUNT_W-1:0] count_queue [$];
	speed_result_t                speed_expect [$];
	speed_result_t                got_res;

	// speed model state
	logic [tach_pkg::COUNT_W-1:0] delta_hist [WINDOW];
	logic [tach_pkg::COUNT_W-1:0] window_total;
	logic [tach_pkg::COUNT_W-1:0] prev_sample;
	logic [tach_pkg::SCALE_W-1:0] scale_model;
	int                           slot;
	int                           fill;

	logic [tach_pkg::COUNT_W-1:0] opening_counts [16] = '{
		32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFF0,
		32'h0000_0010, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
		32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678,
		32'h8000_0000, 32'hFFFF_FFFE, 32'h0000_0005, 32'h0000_0005
	};

	bit steady;
	int holds_asked;
	int holds_taken;
	int hold_left;
	int take_stall;
	int send_gap;
	int mismatches;
	int cycle_count;

	tach_rpm_moving_average_core #(
		.WINDOW(WINDOW)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pulse_count      (pulse_count),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.speed_rpm        (speed_rpm),
		.samples_in_window(samples_in_window)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout at %0t", $time);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic advance_speed_model(input logic [tach_pkg::COUNT_W-1:0] count);
		logic [tach_pkg::COUNT_W-1:0] delta;
		logic [tach_pkg::SPEED_W-1:0] product;
		speed_result_t                res;
		delta = count - prev_sample;
		prev_sample = count;
		window_total = window_total - delta_hist[slot] + delta;
		delta_hist[slot] = delta;
		slot = (slot == WINDOW - 1) ? 0 : slot + 1;
		if (fill < WINDOW)
			fill++;
		product = tach_pkg::SPEED_W'(window_total) * tach_pkg::SPEED_W'(scale_model);
		res.speed = product / tach_pkg::SPEED_W'(fill);
		res.samples = tach_pkg::SAMPLES_W'(fill);
		speed_expect.push_back(res);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pulse_count <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				advance_speed_model(pulse_count);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (count_queue.size() != 0) begin
					pulse_count <= count_queue.pop_front();
					in_valid <= 1'b1;
					send_gap = steady ? 0 : $urandom_range(0, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			take_stall = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (speed_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected transaction speed_rpm=%0d samples_in_window=%0d",
							$time, speed_rpm, samples_in_window);
				end else begin
					got_res = speed_expect.pop_front();
					if (speed_rpm !== got_res.speed) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: speed_rpm expected %0d actual %0d",
								$time, got_res.speed, speed_rpm);
					end
					if (samples_in_window !== got_res.samples) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: samples_in_window expected %0d actual %0d",
								$time, got_res.samples, samples_in_window);
					end
				end
				take_stall = steady ? 0 : $urandom_range(0, 7);
			end
			if (holds_taken < holds_asked) begin
				holds_taken++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (take_stall > 0) begin
				take_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_scale(input logic [tach_pkg::SCALE_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		scale_model = value;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (count_queue.size() != 0 || in_valid || speed_expect.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [tach_pkg::COUNT_W-1:0] gen_count;
		logic [tach_pkg::SCALE_W-1:0] burst_scales [3];
		logic [tach_pkg::SCALE_W-1:0] scale;
		int                           kind;
		burst_scales = '{16'hFFFF, 16'h0000, 16'h0001};
		for (int i = 0; i < WINDOW; i++)
			delta_hist[i] = '0;
		window_total = '0;
		prev_sample = '0;
		scale_model = tach_pkg::SCALE_RESET;
		slot = 0;
		fill = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first sample, wraps and fill saturation at the reset scale
		@(negedge clk);
		foreach (opening_counts[i])
			count_queue.push_back(opening_counts[i]);
		wait_drained();
		gen_count = opening_counts[15];

		// large deltas so the window sum wraps, at the top, zero and unit scales
		foreach (burst_scales[s]) begin
			write_scale(burst_scales[s]);
			@(negedge clk);
			repeat (3) begin
				gen_count = gen_count + 32'hF000_0000 + $urandom_range(0, 255);
				count_queue.push_back(gen_count);
			end
			wait_drained();
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: scale = 16'hFFFF;
				1: scale = 16'h0001;
				2: scale = 16'h0000;
				3: scale = tach_pkg::SCALE_RESET;
				default: scale = tach_pkg::SCALE_W'($urandom_range(1, 65535));
			endcase
			write_scale(scale);
			@(negedge clk);
			steady = (ph == 4 || ph == 7);
			if (ph == 5 || ph == 8)
				holds_asked++;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				kind = $urandom_range(0, 9);
				if (kind < 6)
					gen_count = gen_count + $urandom_range(0, 3000);
				else if (kind < 8)
					gen_count = gen_count + $urandom_range(0, 65535) * $urandom_range(1, 4096);
				else if (kind == 8)
					gen_count = $urandom;
				else
					gen_count = gen_count - $urandom_range(1, 1000);
				count_queue.push_back(gen_count);
			end
			wait_drained();
		end

		if (speed_expect.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected transactions never arrived", $time, speed_expect.size());
		end
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### tach_rpm_moving_average_core.f
hdl/tach_pkg.sv
hdl/tach_ctrl.sv
hdl/tach_dpath.sv
hdl/tach_rpm_moving_average_core.sv
tb/tach_rpm_moving_average_core_tb.sv
